// ===== design/mwm_pkg.sv =====
// Shared types and constants of the mecanum wheel mixer.
// Used by the front end, the item queue, the back end and the top level.
`default_nettype none

package mwm_pkg;

   localparam int VEL_W        = 11;
   localparam int VELZ_W       = 14;
   localparam int YAW_W        = 21;
   localparam int SPEED_W      = 10;
   localparam int LIMIT_W      = 12;
   localparam int GAIN_W       = 16;
   localparam int WHEEL_W      = 13;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   // Internal widths.
   localparam int DIFF_W       = 12;   // vx +/- vy
   localparam int PROD_W       = 31;   // vel_z * gain, or yaw * cruise speed
   localparam int U_W          = 19;   // biased spin quotient by 2048
   localparam int QUOT_W       = 12;   // biased spin quotient by 256000
   localparam int OFF_W        = 15;   // yaw offset
   localparam int MIX_W        = 16;   // wheel sums before clamping

   localparam logic signed [VEL_W-1:0]  VEL_XY_MAX  = 11'sd1000;
   localparam logic signed [VELZ_W-1:0] VEL_Z_MAX   = 14'sd5000;
   localparam logic [SPEED_W-1:0]       SPEED_MAX   = 10'd1000;

   localparam logic [LIMIT_W-1:0] WHEEL_LIMIT_RESET = 12'd1000;
   localparam logic [GAIN_W-1:0]  SPIN_GAIN_RESET   = 16'd256;

   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPIN_GAIN   = 1'b1;

   localparam int DEFAULT_QUEUE_DEPTH = 4;

   // Floor division of the spin product by 256000 = 2048 * 125.
   localparam int                SPIN_SHIFT  = 11;
   localparam logic [U_W-1:0]    DIV_OFFSET  = 19'd160000;  // 125 * 1280
   localparam logic [19:0]       DIV_RECIP   = 20'd536871;  // ceil(2^26 / 125)
   localparam int                RECIP_SHIFT = 26;
   localparam logic [QUOT_W-1:0] QUOT_BIAS   = 12'd1280;
   localparam logic [7:0]        DIV_REM     = 8'd125;
   localparam int                YAW_SHIFT   = 16;

   typedef enum logic [1:0] {
      REQ_VELOCITY = 2'd0,
      REQ_YAW      = 2'd1,
      REQ_MOTION   = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ACT_APPLY = 2'd0,
      ACT_BRAKE = 2'd1,
      ACT_FREE  = 2'd2,
      ACT_HOLD  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      MODE_STOP       = 3'd0,
      MODE_RUN        = 3'd1,
      MODE_BACK       = 3'd2,
      MODE_LEFT       = 3'd3,
      MODE_RIGHT      = 3'd4,
      MODE_SPIN_LEFT  = 3'd5,
      MODE_SPIN_RIGHT = 3'd6,
      MODE_BRAKE      = 3'd7
   } motion_mode_type;

   typedef enum logic [1:0] {
      OP_FIXED = 2'd0,   // result known at the front, wheels zero
      OP_DRIVE = 2'd1,   // mix velocities and store the setpoints
      OP_YAW   = 2'd2    // offset the stored setpoints
   } op_type;

   typedef struct packed {
      op_type                    op;
      action_type                action;
      logic                      yaw_on;
      logic signed [DIFF_W-1:0]  diff;   // vx - vy
      logic signed [DIFF_W-1:0]  sum;    // vx + vy
      logic signed [PROD_W-1:0]  prod;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/mwm_front.sv =====
// Front end of the mecanum wheel mixer: accepts items, classifies them,
// keeps cruise speed and yaw flag, and forms the one product. Uses mwm_pkg.
`default_nettype none

module mwm_front (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_ready,
   input  wire  [1:0]                                  req_type,
   input  wire  signed [mwm_pkg::VEL_W-1:0]            req_vel_x,
   input  wire  signed [mwm_pkg::VEL_W-1:0]            req_vel_y,
   input  wire  signed [mwm_pkg::VELZ_W-1:0]           req_vel_z,
   input  wire  signed [mwm_pkg::YAW_W-1:0]            req_yaw_correction,
   input  wire  [2:0]                                  req_motion_mode,
   input  wire  [mwm_pkg::SPEED_W-1:0]                 req_mode_speed,
   input  wire                                         req_adjust_request,
   input  wire  [mwm_pkg::GAIN_W-1:0]                  spin_gain,
   input  wire                                         queue_ready,
   output logic                                        queue_push,
   output mwm_pkg::entry_type                          queue_entry
);
   import mwm_pkg::*;

   logic [SPEED_W-1:0]             cruise_ff, cruise_in;
   logic                           yaw_flag_ff, yaw_flag_in;

   logic signed [VEL_W-1:0]        vx_sat, vy_sat, dvx, dvy;
   logic signed [VELZ_W-1:0]       vz_sat, dvz;
   logic [SPEED_W-1:0]             spd;
   logic [SPEED_W+2:0]             spd_x5;
   logic                           is_drive;
   op_type                         op;
   action_type                     action;
   logic signed [YAW_W-1:0]        mul_a;
   logic [GAIN_W-1:0]              mul_b;
   logic signed [YAW_W+GAIN_W:0]   prod_full;

   assign req_ready  = queue_ready;
   assign queue_push = req_valid && queue_ready;

   always_comb begin
      if (req_vel_x > VEL_XY_MAX) vx_sat = VEL_XY_MAX;
      else if (req_vel_x < -VEL_XY_MAX) vx_sat = -VEL_XY_MAX;
      else vx_sat = req_vel_x;
      if (req_vel_y > VEL_XY_MAX) vy_sat = VEL_XY_MAX;
      else if (req_vel_y < -VEL_XY_MAX) vy_sat = -VEL_XY_MAX;
      else vy_sat = req_vel_y;
      if (req_vel_z > VEL_Z_MAX) vz_sat = VEL_Z_MAX;
      else if (req_vel_z < -VEL_Z_MAX) vz_sat = -VEL_Z_MAX;
      else vz_sat = req_vel_z;
      spd    = (req_mode_speed > SPEED_MAX) ? SPEED_MAX : req_mode_speed;
      spd_x5 = {1'b0, spd, 2'b00} + {3'b000, spd};
   end

   always_comb begin
      op          = OP_FIXED;
      action      = ACT_HOLD;
      yaw_flag_in = yaw_flag_ff;
      cruise_in   = cruise_ff;
      is_drive    = 1'b0;
      dvx         = '0;
      dvy         = '0;
      dvz         = '0;
      case (req_type)
         REQ_VELOCITY: begin
            is_drive = 1'b1;
            dvx      = vx_sat;
            dvy      = vy_sat;
            dvz      = vz_sat;
         end
         REQ_YAW: begin
            op     = OP_YAW;
            action = ACT_APPLY;
         end
         REQ_MOTION: begin
            yaw_flag_in = req_adjust_request;
            cruise_in   = spd;
            case (req_motion_mode)
               MODE_STOP: begin
                  cruise_in = '0;
                  action    = (spd == '0) ? ACT_FREE : ACT_BRAKE;
               end
               MODE_RUN: begin
                  is_drive = 1'b1;
                  dvx      = $signed({1'b0, spd});
               end
               MODE_BACK: begin
                  is_drive = 1'b1;
                  dvx      = -$signed({1'b0, spd});
               end
               MODE_LEFT: begin
                  is_drive = 1'b1;
                  dvy      = $signed({1'b0, spd});
               end
               MODE_RIGHT: begin
                  is_drive = 1'b1;
                  dvy      = -$signed({1'b0, spd});
               end
               MODE_SPIN_LEFT: begin
                  is_drive    = 1'b1;
                  yaw_flag_in = 1'b0;
                  dvz         = $signed({1'b0, spd_x5});
               end
               MODE_SPIN_RIGHT: begin
                  is_drive    = 1'b1;
                  yaw_flag_in = 1'b0;
                  dvz         = -$signed({1'b0, spd_x5});
               end
               default: begin
                  action = ACT_BRAKE;
               end
            endcase
         end
         default: begin
            op     = OP_FIXED;
            action = ACT_HOLD;
         end
      endcase
      // A drive with no motion at all is a brake and leaves the setpoints alone.
      if (is_drive) begin
         if (dvx == '0 && dvy == '0 && dvz == '0) begin
            op     = OP_FIXED;
            action = ACT_BRAKE;
         end else begin
            op     = OP_DRIVE;
            action = ACT_APPLY;
         end
      end
   end

   // One multiplier serves both the spin term and the yaw offset.
   always_comb begin
      if (op == OP_YAW) begin
         mul_a = req_yaw_correction;
         mul_b = {{(GAIN_W-SPEED_W){1'b0}}, cruise_ff};
      end else begin
         mul_a = YAW_W'(dvz);
         mul_b = spin_gain;
      end
      prod_full = mul_a * $signed({1'b0, mul_b});
   end

   always_comb begin
      queue_entry.op     = op;
      queue_entry.action = action;
      queue_entry.yaw_on = yaw_flag_in;
      queue_entry.diff   = DIFF_W'(dvx) - DIFF_W'(dvy);
      queue_entry.sum    = DIFF_W'(dvx) + DIFF_W'(dvy);
      queue_entry.prod   = prod_full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_ff   <= '0;
         yaw_flag_ff <= 1'b0;
      end else if (queue_push) begin
         cruise_ff   <= cruise_in;
         yaw_flag_ff <= yaw_flag_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mwm_fifo.sv =====
// Short item queue between the front and back ends of the wheel mixer.
// Holds mwm_pkg::entry_type items; depth set by a parameter.
`default_nettype none

module mwm_fifo #(
   parameter int DEPTH = mwm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  mwm_pkg::entry_type  push_entry,
   output logic                push_ready,
   input  wire                 pop,
   output logic                head_valid,
   output mwm_pkg::entry_type  head_entry
);
   import mwm_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign push_ready = !reset && (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds its depth");

   assert property (@(posedge clock) disable iff (reset) pop |-> count_ff != '0)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff != '0) && (wr_ptr_ff != $past(wr_ptr_ff) || DEPTH == 1))
      else $error("queue transfer in did not advance the write side");

endmodule

`default_nettype wire

// ===== design/mwm_back.sv =====
// Back end of the wheel mixer: divides the spin product, mixes and clamps
// the wheel setpoints and holds the result register. Uses mwm_pkg.
`default_nettype none

module mwm_back (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   head_valid,
   input  mwm_pkg::entry_type                    head_entry,
   output logic                                  pop,
   input  wire  [mwm_pkg::LIMIT_W-1:0]           wheel_limit,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [1:0]                            rsp_motor_action,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_front_left,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_rear_left,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_front_right,
   output logic signed [mwm_pkg::WHEEL_W-1:0]    rsp_wheel_rear_right,
   output logic                                  rsp_yaw_adjust_on
);
   import mwm_pkg::*;

   function automatic logic signed [MIX_W-1:0] trunc_zero(
      input logic signed [MIX_W-1:0] t,
      input logic                    rem_nz
   );
      logic signed [MIX_W-1:0] r;
      r = t;
      // A negative floor quotient with a remainder rounds one up toward zero.
      if (t[MIX_W-1] && rem_nz) r = t + $signed(MIX_W'(1));
      return r;
   endfunction

   function automatic logic signed [WHEEL_W-1:0] clamp_wheel(
      input logic signed [MIX_W-1:0] v,
      input logic [LIMIT_W-1:0]      lim
   );
      logic signed [MIX_W-1:0] hi;
      logic signed [MIX_W-1:0] r;
      hi = $signed(MIX_W'(lim));
      if (v > hi) r = hi;
      else if (v < -hi) r = -hi;
      else r = v;
      return r[WHEEL_W-1:0];
   endfunction

   logic                      advance;

   // Stage 1: reciprocal multiply and yaw offset.
   logic                      s1_valid_ff;
   entry_type                 s1_entry_ff;
   logic [U_W-1:0]            s1_u_ff;
   logic [QUOT_W-1:0]         s1_quot_ff;
   logic                      s1_r0nz_ff;
   logic signed [OFF_W-1:0]   s1_off_ff;

   logic signed [PROD_W-1:0]  shifted;
   logic signed [PROD_W-1:0]  u_wide;
   logic [U_W-1:0]            u_in;
   logic [U_W+19:0]           recip_prod;
   logic signed [PROD_W-1:0]  yaw_bias;
   logic signed [PROD_W-1:0]  off_wide;

   // Stage 2: quotients and remainder flag.
   logic                      s2_valid_ff;
   entry_type                 s2_entry_ff;
   logic signed [QUOT_W-1:0]  s2_qp_ff, s2_qm_ff;
   logic                      s2_rnz_ff;
   logic signed [OFF_W-1:0]   s2_off_ff;

   logic signed [QUOT_W-1:0]  qp_in, qm_in;
   logic [U_W-1:0]            r1;
   logic                      rnz_in;

   // Stored setpoints and the result register.
   logic signed [WHEEL_W-1:0] sp_fl_ff, sp_rl_ff, sp_fr_ff, sp_rr_ff;
   logic signed [WHEEL_W-1:0] mix_fl, mix_rl, mix_fr, mix_rr;
   logic signed [WHEEL_W-1:0] yaw_fl, yaw_rl, yaw_fr, yaw_rr;
   logic signed [WHEEL_W-1:0] res_fl, res_rl, res_fr, res_rr;
   logic signed [MIX_W-1:0]   off_ext;

   logic                      out_valid_ff;
   logic [1:0]                out_action_ff;
   logic signed [WHEEL_W-1:0] out_fl_ff, out_rl_ff, out_fr_ff, out_rr_ff;
   logic                      out_yaw_ff;

   assign advance = !out_valid_ff || rsp_ready;
   assign pop     = advance && head_valid;

   always_comb begin
      shifted    = head_entry.prod >>> SPIN_SHIFT;
      u_wide     = shifted + $signed(PROD_W'(DIV_OFFSET));
      u_in       = u_wide[U_W-1:0];
      recip_prod = u_in * DIV_RECIP;
      yaw_bias   = head_entry.prod[PROD_W-1] ? $signed(PROD_W'((1 << YAW_SHIFT) - 1)) : '0;
      off_wide   = (head_entry.prod + yaw_bias) >>> YAW_SHIFT;
   end

   always_comb begin
      qp_in  = $signed(s1_quot_ff - QUOT_BIAS);
      r1     = s1_u_ff - U_W'(s1_quot_ff * DIV_REM);
      rnz_in = s1_r0nz_ff || (r1 != '0);
      qm_in  = rnz_in ? (-qp_in - $signed(QUOT_W'(1))) : -qp_in;
   end

   always_comb begin
      mix_fl  = clamp_wheel(trunc_zero(MIX_W'(s2_entry_ff.diff) + MIX_W'(s2_qm_ff), s2_rnz_ff),
                            wheel_limit);
      mix_rl  = clamp_wheel(trunc_zero(MIX_W'(s2_entry_ff.sum) + MIX_W'(s2_qm_ff), s2_rnz_ff),
                            wheel_limit);
      mix_fr  = clamp_wheel(trunc_zero(MIX_W'(s2_entry_ff.sum) + MIX_W'(s2_qp_ff), s2_rnz_ff),
                            wheel_limit);
      mix_rr  = clamp_wheel(trunc_zero(MIX_W'(s2_entry_ff.diff) + MIX_W'(s2_qp_ff), s2_rnz_ff),
                            wheel_limit);
      off_ext = MIX_W'(s2_off_ff);
      yaw_fl  = clamp_wheel(MIX_W'(sp_fl_ff) - off_ext, wheel_limit);
      yaw_rl  = clamp_wheel(MIX_W'(sp_rl_ff) - off_ext, wheel_limit);
      yaw_fr  = clamp_wheel(MIX_W'(sp_fr_ff) + off_ext, wheel_limit);
      yaw_rr  = clamp_wheel(MIX_W'(sp_rr_ff) + off_ext, wheel_limit);
      case (s2_entry_ff.op)
         OP_DRIVE: begin
            res_fl = mix_fl;
            res_rl = mix_rl;
            res_fr = mix_fr;
            res_rr = mix_rr;
         end
         OP_YAW: begin
            res_fl = yaw_fl;
            res_rl = yaw_rl;
            res_fr = yaw_fr;
            res_rr = yaw_rr;
         end
         default: begin
            res_fl = '0;
            res_rl = '0;
            res_fr = '0;
            res_rr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_entry_ff   <= head_entry;
         s1_u_ff       <= u_in;
         s1_quot_ff    <= recip_prod[RECIP_SHIFT +: QUOT_W];
         s1_r0nz_ff    <= |head_entry.prod[SPIN_SHIFT-1:0];
         s1_off_ff     <= off_wide[OFF_W-1:0];
         s2_entry_ff   <= s1_entry_ff;
         s2_qp_ff      <= qp_in;
         s2_qm_ff      <= qm_in;
         s2_rnz_ff     <= rnz_in;
         s2_off_ff     <= s1_off_ff;
         out_action_ff <= s2_entry_ff.action;
         out_yaw_ff    <= s2_entry_ff.yaw_on;
         out_fl_ff     <= res_fl;
         out_rl_ff     <= res_rl;
         out_fr_ff     <= res_fr;
         out_rr_ff     <= res_rr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sp_fl_ff     <= '0;
         sp_rl_ff     <= '0;
         sp_fr_ff     <= '0;
         sp_rr_ff     <= '0;
      end else if (advance) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
         if (s2_valid_ff && s2_entry_ff.op == OP_DRIVE) begin
            sp_fl_ff <= mix_fl;
            sp_rl_ff <= mix_rl;
            sp_fr_ff <= mix_fr;
            sp_rr_ff <= mix_rr;
         end
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_motor_action      = out_action_ff;
   assign rsp_wheel_front_left  = out_fl_ff;
   assign rsp_wheel_rear_left   = out_rl_ff;
   assign rsp_wheel_front_right = out_fr_ff;
   assign rsp_wheel_rear_right  = out_rr_ff;
   assign rsp_yaw_adjust_on     = out_yaw_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_action_ff != ACT_APPLY) |->
         (out_fl_ff == '0 && out_rl_ff == '0 && out_fr_ff == '0 && out_rr_ff == '0))
      else $error("non-apply result carries wheel speeds");

   assert property (@(posedge clock) disable iff (reset)
      !(advance && s2_valid_ff && s2_entry_ff.op == OP_DRIVE) |=>
         ($stable(sp_fl_ff) && $stable(sp_rr_ff)))
      else $error("setpoints changed without a drive transfer");

endmodule

`default_nettype wire

// ===== design/mecanum_wheel_mixer.sv =====
// Top level of the four-wheel mecanum mixer: configuration registers and the
// front end, item queue and back end. Depends on mwm_pkg and its submodules.
//
//   channel   handshake                  payload
//   req       req_valid / req_ready      type, velocities, yaw, mode, speed, adjust
//   rsp       rsp_valid / rsp_ready      motor action, four wheel setpoints, yaw flag
//   csr       csr_wr_en                  csr_index, csr_wdata
//
// One item per clock is sustained while rsp_ready holds; a result passes from its
// transfer in through the queue read, spin divide, and mix and clamp registers.
// The queue holds QUEUE_DEPTH items, so req_ready stays high while a result
// waits on rsp_ready until the queue fills. Reset clears the stored setpoints,
// cruise speed and yaw flag, loads the register defaults and empties the queue.
`default_nettype none

module mecanum_wheel_mixer #(
   parameter int QUEUE_DEPTH = mwm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       csr_wr_en,
   input  wire  [mwm_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  wire  [mwm_pkg::CSR_DATA_W-1:0]            csr_wdata,
   input  wire                                       req_valid,
   output logic                                      req_ready,
   input  wire  [1:0]                                req_type,
   input  wire  signed [mwm_pkg::VEL_W-1:0]          req_vel_x,
   input  wire  signed [mwm_pkg::VEL_W-1:0]          req_vel_y,
   input  wire  signed [mwm_pkg::VELZ_W-1:0]         req_vel_z,
   input  wire  signed [mwm_pkg::YAW_W-1:0]          req_yaw_correction,
   input  wire  [2:0]                                req_motion_mode,
   input  wire  [mwm_pkg::SPEED_W-1:0]               req_mode_speed,
   input  wire                                       req_adjust_request,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output logic [1:0]                                rsp_motor_action,
   output logic signed [mwm_pkg::WHEEL_W-1:0]        rsp_wheel_front_left,
   output logic signed [mwm_pkg::WHEEL_W-1:0]        rsp_wheel_rear_left,
   output logic signed [mwm_pkg::WHEEL_W-1:0]        rsp_wheel_front_right,
   output logic signed [mwm_pkg::WHEEL_W-1:0]        rsp_wheel_rear_right,
   output logic                                      rsp_yaw_adjust_on
);
   import mwm_pkg::*;

   logic [LIMIT_W-1:0]  wheel_limit_ff;
   logic [GAIN_W-1:0]   spin_gain_ff;

   logic                queue_push;
   logic                queue_ready;
   entry_type           queue_entry;
   logic                queue_pop;
   logic                head_valid;
   entry_type           head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_limit_ff <= WHEEL_LIMIT_RESET;
         spin_gain_ff   <= SPIN_GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WHEEL_LIMIT: wheel_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_SPIN_GAIN:   spin_gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: begin
               wheel_limit_ff <= wheel_limit_ff;
            end
         endcase
      end
   end

   mwm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_vel_x          (req_vel_x),
      .req_vel_y          (req_vel_y),
      .req_vel_z          (req_vel_z),
      .req_yaw_correction (req_yaw_correction),
      .req_motion_mode    (req_motion_mode),
      .req_mode_speed     (req_mode_speed),
      .req_adjust_request (req_adjust_request),
      .spin_gain          (spin_gain_ff),
      .queue_ready        (queue_ready),
      .queue_push         (queue_push),
      .queue_entry        (queue_entry)
   );

   mwm_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .push_ready (queue_ready),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mwm_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (head_valid),
      .head_entry            (head_entry),
      .pop                   (queue_pop),
      .wheel_limit           (wheel_limit_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_motor_action      (rsp_motor_action),
      .rsp_wheel_front_left  (rsp_wheel_front_left),
      .rsp_wheel_rear_left   (rsp_wheel_rear_left),
      .rsp_wheel_front_right (rsp_wheel_front_right),
      .rsp_wheel_rear_right  (rsp_wheel_rear_right),
      .rsp_yaw_adjust_on     (rsp_yaw_adjust_on)
   );

endmodule

`default_nettype wire

// ===== dv/mixer_check_pkg.sv =====
`timescale 1ns / 100ps
// Transfer types and the wheel setpoint scoreboard for the mecanum mixer test.
// Depends on mwm_pkg for widths, register resets and the action and mode codes.

package mixer_check_pkg;

   import mwm_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam longint SPIN_SCALE       = 256000;
   localparam longint YAW_SCALE        = 65536;
   localparam longint VEL_LIMIT        = 1000;
   localparam longint SPIN_LIMIT       = 5000;
   localparam longint MODE_SPEED_LIMIT = 1000;
   localparam longint SPIN_MULT        = 5;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [VEL_W-1:0]    vel_x;
      logic signed [VEL_W-1:0]    vel_y;
      logic signed [VELZ_W-1:0]   vel_z;
      logic signed [YAW_W-1:0]    yaw;
      motion_mode_type            mode;
      logic [SPEED_W-1:0]         speed;
      logic                       adjust;
   } mix_request_type;

   typedef struct packed {
      action_type                 action;
      logic signed [WHEEL_W-1:0]  front_left;
      logic signed [WHEEL_W-1:0]  rear_left;
      logic signed [WHEEL_W-1:0]  front_right;
      logic signed [WHEEL_W-1:0]  rear_right;
      logic                       yaw_on;
   } wheel_result_type;

   class wheel_setpoint_board;
      logic [LIMIT_W-1:0] limit_reg;
      logic [GAIN_W-1:0]  gain_reg;
      longint             set_fl, set_rl, set_fr, set_rr;
      longint             cruise;
      logic               yaw_flag;
      wheel_result_type   pending_setpoints[$];
      int                 mismatch_count;

      function new();
         limit_reg = WHEEL_LIMIT_RESET;
         gain_reg = SPIN_GAIN_RESET;
         set_fl = 0;
         set_rl = 0;
         set_fr = 0;
         set_rr = 0;
         cruise = 0;
         yaw_flag = 1'b0;
         mismatch_count = 0;
      endfunction

      function void load_registers(logic [CSR_DATA_W-1:0] limit_word,
                                   logic [CSR_DATA_W-1:0] gain_word);
         limit_reg = limit_word[LIMIT_W-1:0];
         gain_reg = gain_word[GAIN_W-1:0];
      endfunction

      function longint bound(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function wheel_result_type wheels_out(action_type act, longint fl, longint rl,
                                            longint fr, longint rr);
         wheel_result_type res;
         res.action = act;
         res.front_left = fl[WHEEL_W-1:0];
         res.rear_left = rl[WHEEL_W-1:0];
         res.front_right = fr[WHEEL_W-1:0];
         res.rear_right = rr[WHEEL_W-1:0];
         res.yaw_on = yaw_flag;
         return res;
      endfunction

      // The spin term is kept exact over the common denominator so that only
      // the final division truncates toward zero.
      function wheel_result_type mix_velocity(longint vx, longint vy, longint vz);
         longint fb, lr, sp, lim;
         if (vx == 0 && vy == 0 && vz == 0) return wheels_out(ACT_BRAKE, 0, 0, 0, 0);
         lim = longint'(limit_reg);
         fb = vx * SPIN_SCALE;
         lr = -vy * SPIN_SCALE;
         sp = -vz * longint'(gain_reg);
         set_fl = bound((fb + lr + sp) / SPIN_SCALE, lim);
         set_rl = bound((fb - lr + sp) / SPIN_SCALE, lim);
         set_fr = bound((fb - lr - sp) / SPIN_SCALE, lim);
         set_rr = bound((fb + lr - sp) / SPIN_SCALE, lim);
         return wheels_out(ACT_APPLY, set_fl, set_rl, set_fr, set_rr);
      endfunction

      function void note_request(mix_request_type r);
         longint           spd, off, lim;
         wheel_result_type res;
         lim = longint'(limit_reg);
         case (r.kind)
            REQ_VELOCITY: res = mix_velocity(bound(r.vel_x, VEL_LIMIT),
                                             bound(r.vel_y, VEL_LIMIT),
                                             bound(r.vel_z, SPIN_LIMIT));
            REQ_YAW: begin
               // The stored setpoints are offset for this result only.
               off = (longint'(r.yaw) * cruise) / YAW_SCALE;
               res = wheels_out(ACT_APPLY, bound(set_fl - off, lim), bound(set_rl - off, lim),
                                bound(set_fr + off, lim), bound(set_rr + off, lim));
            end
            REQ_MOTION: begin
               spd = longint'(r.speed);
               if (spd > MODE_SPEED_LIMIT) spd = MODE_SPEED_LIMIT;
               yaw_flag = r.adjust;
               cruise = spd;
               case (r.mode)
                  MODE_STOP: begin
                     cruise = 0;
                     res = wheels_out(spd == 0 ? ACT_FREE : ACT_BRAKE, 0, 0, 0, 0);
                  end
                  MODE_RUN:   res = mix_velocity(spd, 0, 0);
                  MODE_BACK:  res = mix_velocity(-spd, 0, 0);
                  MODE_LEFT:  res = mix_velocity(0, spd, 0);
                  MODE_RIGHT: res = mix_velocity(0, -spd, 0);
                  MODE_SPIN_LEFT: begin
                     yaw_flag = 1'b0;
                     res = mix_velocity(0, 0, spd * SPIN_MULT);
                  end
                  MODE_SPIN_RIGHT: begin
                     yaw_flag = 1'b0;
                     res = mix_velocity(0, 0, -spd * SPIN_MULT);
                  end
                  default: res = wheels_out(ACT_BRAKE, 0, 0, 0, 0);
               endcase
            end
            default: res = wheels_out(ACT_HOLD, 0, 0, 0, 0);
         endcase
         pending_setpoints.push_back(res);
      endfunction

      function void check_result(wheel_result_type got);
         wheel_result_type want;
         if (pending_setpoints.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with nothing outstanding: action %0d wheels %0d %0d %0d %0d",
                        $realtime, got.action, got.front_left, got.rear_left,
                        got.front_right, got.rear_right);
            return;
         end
         want = pending_setpoints.pop_front();
         if (got.action != want.action || got.front_left != want.front_left ||
             got.rear_left != want.rear_left || got.front_right != want.front_right ||
             got.rear_right != want.rear_right || got.yaw_on != want.yaw_on) begin
            mismatch_count++;
            // Fields in order: action, four wheels, yaw flag.
            if (mismatch_count <= 10)
               $display("%0t: expected %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d",
                        $realtime, want.action, want.front_left, want.rear_left,
                        want.front_right, want.rear_right, want.yaw_on,
                        got.action, got.front_left, got.rear_left,
                        got.front_right, got.rear_right, got.yaw_on);
         end
      endfunction
   endclass

endpackage

// ===== dv/mecanum_wheel_mixer_test.sv =====
`timescale 1ns / 100ps
// Self-checking test of mecanum_wheel_mixer: directed and random commands with
// random idling on both channels. Depends on mwm_pkg and mixer_check_pkg.

module mecanum_wheel_mixer_test;

   import mwm_pkg::*;
   import mixer_check_pkg::*;

   localparam int CYCLE_LIMIT      = 300000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int SEGMENT_ITEMS    = 115;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_type = '0;
   logic signed [VEL_W-1:0]    req_vel_x = '0;
   logic signed [VEL_W-1:0]    req_vel_y = '0;
   logic signed [VELZ_W-1:0]   req_vel_z = '0;
   logic signed [YAW_W-1:0]    req_yaw_correction = '0;
   logic [2:0]                 req_motion_mode = '0;
   logic [SPEED_W-1:0]         req_mode_speed = '0;
   logic                       req_adjust_request = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_motor_action;
   logic signed [WHEEL_W-1:0]  rsp_wheel_front_left;
   logic signed [WHEEL_W-1:0]  rsp_wheel_rear_left;
   logic signed [WHEEL_W-1:0]  rsp_wheel_front_right;
   logic signed [WHEEL_W-1:0]  rsp_wheel_rear_right;
   logic                       rsp_yaw_adjust_on;

   int                  sender_idle_pct = 18;
   int                  receiver_idle_pct = 72;
   logic                long_hold_request = 1'b0;
   logic                long_hold_done = 1'b0;
   int                  cycle_count = 0;
   wheel_setpoint_board board = new();

   mecanum_wheel_mixer dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_vel_x             (req_vel_x),
      .req_vel_y             (req_vel_y),
      .req_vel_z             (req_vel_z),
      .req_yaw_correction    (req_yaw_correction),
      .req_motion_mode       (req_motion_mode),
      .req_mode_speed        (req_mode_speed),
      .req_adjust_request    (req_adjust_request),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_motor_action      (rsp_motor_action),
      .rsp_wheel_front_left  (rsp_wheel_front_left),
      .rsp_wheel_rear_left   (rsp_wheel_rear_left),
      .rsp_wheel_front_right (rsp_wheel_front_right),
      .rsp_wheel_rear_right  (rsp_wheel_rear_right),
      .rsp_yaw_adjust_on     (rsp_yaw_adjust_on)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL mecanum_wheel_mixer");
         $finish;
      end
   end

   // Both channels are sampled with their values from before the edge.
   always @(posedge clock) begin : transfer_monitor
      mix_request_type  seen;
      wheel_result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.kind = req_type;
            seen.vel_x = req_vel_x;
            seen.vel_y = req_vel_y;
            seen.vel_z = req_vel_z;
            seen.yaw = req_yaw_correction;
            seen.mode = motion_mode_type'(req_motion_mode);
            seen.speed = req_mode_speed;
            seen.adjust = req_adjust_request;
            board.note_request(seen);
         end
         if (rsp_valid && rsp_ready) begin
            got.action = action_type'(rsp_motor_action);
            got.front_left = rsp_wheel_front_left;
            got.rear_left = rsp_wheel_rear_left;
            got.front_right = rsp_wheel_front_right;
            got.rear_right = rsp_wheel_rear_right;
            got.yaw_on = rsp_yaw_adjust_on;
            board.check_result(got);
         end
      end
   end

   // The long hold lets the mixer fill up and push back on the command side.
   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (long_hold_request && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   function automatic mix_request_type command(logic [1:0] kind, int vx, int vy, int vz,
                                               int yaw, motion_mode_type mode, int speed,
                                               logic adjust);
      mix_request_type r;
      r.kind = kind;
      r.vel_x = VEL_W'(vx);
      r.vel_y = VEL_W'(vy);
      r.vel_z = VELZ_W'(vz);
      r.yaw = YAW_W'(yaw);
      r.mode = mode;
      r.speed = SPEED_W'(speed);
      r.adjust = adjust;
      return r;
   endfunction

   // Raw random values cover every bit and the saturating ranges; most
   // commands are then pulled into the legal ranges.
   function automatic mix_request_type random_command();
      mix_request_type r;
      int              pick;
      r.vel_x = VEL_W'($urandom);
      r.vel_y = VEL_W'($urandom);
      r.vel_z = VELZ_W'($urandom);
      r.yaw = YAW_W'($urandom);
      r.mode = motion_mode_type'($urandom_range(7));
      r.speed = SPEED_W'($urandom);
      r.adjust = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) r.kind = REQ_VELOCITY;
      else if (pick < 60) r.kind = REQ_YAW;
      else if (pick < 95) r.kind = REQ_MOTION;
      else r.kind = REQ_UNUSED;
      if ($urandom_range(9) != 0) begin
         r.vel_x = VEL_W'(int'($urandom_range(2000)) - 1000);
         r.vel_y = VEL_W'(int'($urandom_range(2000)) - 1000);
         r.vel_z = VELZ_W'(int'($urandom_range(10000)) - 5000);
         r.speed = SPEED_W'($urandom_range(1000));
      end
      if ($urandom_range(11) == 0) begin
         r.vel_x = '0;
         r.vel_y = '0;
         r.vel_z = '0;
      end
      if ($urandom_range(9) == 0) r.speed = '0;
      if ($urandom_range(3) == 0) r.yaw = YAW_W'(int'($urandom_range(131072)) - 65536);
      return r;
   endfunction

   task automatic offer_command(input mix_request_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= item.kind;
      req_vel_x <= item.vel_x;
      req_vel_y <= item.vel_y;
      req_vel_z <= item.vel_z;
      req_yaw_correction <= item.yaw;
      req_motion_mode <= item.mode;
      req_mode_speed <= item.speed;
      req_adjust_request <= item.adjust;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // One edge first so that the monitor has seen the last transfer in.
   task automatic drain_mixer();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_setpoints.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_W-1:0] limit_word,
                                  input logic [CSR_DATA_W-1:0] gain_word);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WHEEL_LIMIT;
      csr_wdata <= limit_word;
      @(posedge clock);
      csr_index <= CSR_SPIN_GAIN;
      csr_wdata <= gain_word;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.load_registers(limit_word, gain_word);
   endtask

   initial begin : stimulus
      int                    seg;
      int                    n;
      logic [CSR_DATA_W-1:0] limit_word;
      logic [CSR_DATA_W-1:0] gain_word;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      offer_command(command(REQ_VELOCITY, 0, 0, 0, 0, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_VELOCITY, 1000, 0, 0, 0, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_VELOCITY, -1024, 1023, 0, 0, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_VELOCITY, 1023, -1024, -8192, 0, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_VELOCITY, 0, 0, 8191, 0, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_VELOCITY, -1000, -1000, -5000, 0, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_VELOCITY, 0, 0, 1, 0, MODE_STOP, 0, 1'b0));
      // With no cruise speed the correction leaves the setpoints alone.
      offer_command(command(REQ_YAW, 0, 0, 0, 1048575, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_STOP, 0, 1'b1));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_STOP, 500, 1'b0));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_RUN, 1023, 1'b1));
      offer_command(command(REQ_YAW, 0, 0, 0, 1048575, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_YAW, 0, 0, 0, -1048576, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_BACK, 300, 1'b1));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_LEFT, 999, 1'b0));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_RIGHT, 1, 1'b1));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_SPIN_LEFT, 1000, 1'b1));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_SPIN_RIGHT, 200, 1'b1));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_BRAKE, 700, 1'b1));
      offer_command(command(REQ_YAW, 0, 0, 0, 65536, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_YAW, 0, 0, 0, -70000, MODE_STOP, 0, 1'b0));
      offer_command(command(REQ_UNUSED, 5, -5, 77, 12345, MODE_RUN, 900, 1'b1));
      offer_command(command(REQ_MOTION, 0, 0, 0, 0, MODE_RUN, 0, 1'b1));
      offer_command(command(REQ_VELOCITY, 3, -2, -1, 0, MODE_STOP, 0, 1'b0));

      for (seg = 0; seg < 6; seg++) begin
         drain_mixer();
         case (seg)
            0: begin
               limit_word = CSR_DATA_W'(WHEEL_LIMIT_RESET);
               gain_word = SPIN_GAIN_RESET;
            end
            1: begin
               limit_word = 16'hFFFF;
               gain_word = 16'hFFFF;
            end
            2: begin
               limit_word = '0;
               gain_word = '0;
               sender_idle_pct = 72;
               receiver_idle_pct = 18;
            end
            3: begin
               // Bits above the limit field must be dropped.
               limit_word = {4'($urandom), 12'($urandom_range(4094, 1))};
               gain_word = CSR_DATA_W'($urandom);
            end
            4: begin
               limit_word = 16'h0FFF;
               gain_word = '0;
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
            default: begin
               limit_word = CSR_DATA_W'($urandom_range(900, 200));
               gain_word = CSR_DATA_W'($urandom_range(3000, 1000));
            end
         endcase
         write_registers(limit_word, gain_word);
         if (seg == 0) long_hold_request = 1'b1;
         for (n = 0; n < SEGMENT_ITEMS; n++) offer_command(random_command());
      end

      drain_mixer();
      repeat (10) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_setpoints.size() == 0)
         $display("PASS mecanum_wheel_mixer");
      else
         $display("FAIL mecanum_wheel_mixer");
      $finish;
   end

endmodule
